### src/cpta_pkg.sv
// Shared types, widths and codes for the contact point table aggregator.
// Used by contact_point_table_aggregator and its testbench; depends on nothing.
package cpta_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int POS_W     = 24;
  localparam int FORCE_W   = 32;
  localparam int AFFECT_W  = 16;
  localparam int SUM_W     = 40;
  localparam int THR_W     = 52;
  localparam int CAP_W     = 5;
  localparam int CFG_W     = 52;
  localparam int CFG_IDX_W = 2;

  localparam int SQ_W       = 2 * POS_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int PROD_W     = FORCE_W + AFFECT_W;
  localparam int ACC_W      = PROD_W + CNT_W;
  localparam int FRAC_SHIFT = 15;

  localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [THR_W-1:0]   DIST_THR_RST  = THR_W'(429497);
  localparam logic [FORCE_W-1:0] MIN_FORCE_RST = FORCE_W'(655);
  localparam logic [CAP_W-1:0]   CAP_LIMIT_RST = CAP_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_THR,
    CFG_MIN_FORCE,
    CFG_CAP_LIMIT
  } cfg_idx_t;

  typedef enum logic {
    OP_ADD,
    OP_FRAME
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_MERGED,
    ST_APPENDED,
    ST_REPLACED
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic        [FORCE_W-1:0] point_force;
    logic        [AFFECT_W-1:0] affect_weight;
  } in_item_t;

  typedef struct packed {
    status_t            add_status;
    logic [SUM_W-1:0]   frame_sum;
    logic [CNT_W-1:0]   entry_count;
  } out_item_t;

  // Position and weight of one table entry, kept apart from the force.
  typedef struct packed {
    logic [AFFECT_W-1:0]     affect;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } geo_t;

endpackage

### src/cpta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module cpta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/contact_point_table_aggregator.sv
// Top level of the contact point table aggregator: sequencer, scan pipeline
// and two table RAMs. Depends on cpta_pkg and cpta_ram.
//
// Usage: a beat is offered on in_item with start and is taken at an edge where
// busy is low. An add beat drops a weak point, merges into the first stored
// entry within the distance threshold, appends, or replaces the weakest entry.
// A frame beat empties the table and returns saturated sum(affect*force)>>15.
// Exactly one result beat follows each input beat, shown on out_item for one
// cycle with out_valid; the receiver cannot hold it off.
// Timing: the table walk reads one entry per cycle from the RAMs through a
// two-stage compare pipeline until every occupied entry is compared. An item
// on an empty table reads no entry, a dropped add skips the walk, and a merge
// ends the walk early. busy falls in the cycle out_valid is shown, so the next
// beat can be taken then. The table holds at most TABLE_DEPTH entries.
// Configuration is written on cfg_we/cfg_index/cfg_wdata by the user only while idle; the block does not enforce it.
// Reset (rst_n low at an edge) empties the table and restores the register
// defaults; table RAM contents are not cleared and need not be.
module contact_point_table_aggregator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cpta_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output cpta_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [cpta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpta_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [cpta_pkg::THR_W-1:0]   thr_r;
  logic [cpta_pkg::FORCE_W-1:0] min_force_r;
  logic [cpta_pkg::CAP_W-1:0]   cap_r;

  // Control.
  cpta_pkg::state_t           state_r, state_nxt;
  logic [cpta_pkg::CNT_W-1:0] occ_r, occ_nxt;
  logic [cpta_pkg::CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                       v1_r, v1_nxt;
  logic                       v2_r, v2_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Payload.
  cpta_pkg::in_item_t           item_r, item_nxt;
  logic                         drop_r, drop_nxt;
  logic                         hit_r, hit_nxt;
  logic [cpta_pkg::IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [cpta_pkg::IDX_W-1:0]   idx1_r, idx1_nxt;
  logic [cpta_pkg::IDX_W-1:0]   idx2_r, idx2_nxt;
  logic [cpta_pkg::SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic [cpta_pkg::SQ_W-1:0]    sqx_nxt, sqy_nxt, sqz_nxt;
  logic [cpta_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [cpta_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [cpta_pkg::FORCE_W-1:0] low_force_r, low_force_nxt;
  logic [cpta_pkg::IDX_W-1:0]   low_idx_r, low_idx_nxt;
  cpta_pkg::out_item_t          out_item_r, out_item_nxt;

  // RAM ports.
  logic                         geo_we, force_we;
  logic [cpta_pkg::IDX_W-1:0]   waddr;
  cpta_pkg::geo_t               geo_wdata, geo_rdata;
  logic [cpta_pkg::FORCE_W-1:0] force_rdata;

  // Datapath signals.
  logic                          accept;
  logic                          more;
  logic                          issue;
  logic                          hit;
  logic                          is_frame;
  logic [cpta_pkg::CNT_W-1:0]    cap_eff;
  logic                          full;
  logic signed [cpta_pkg::POS_W:0] dx, dy, dz;
  logic [cpta_pkg::POS_W-1:0]    ax, ay, az;
  logic [cpta_pkg::DIST_W-1:0]   dist_sq;
  logic [cpta_pkg::ACC_W-1:0]    acc_shift;

  cpta_ram #(
    .WIDTH($bits(cpta_pkg::geo_t)),
    .DEPTH(cpta_pkg::TABLE_DEPTH)
  ) u_geo_ram (
    .clk  (clk),
    .we   (geo_we),
    .waddr(waddr),
    .wdata(geo_wdata),
    .raddr(rd_idx_r[cpta_pkg::IDX_W-1:0]),
    .rdata(geo_rdata)
  );

  cpta_ram #(
    .WIDTH(cpta_pkg::FORCE_W),
    .DEPTH(cpta_pkg::TABLE_DEPTH)
  ) u_force_ram (
    .clk  (clk),
    .we   (force_we),
    .waddr(waddr),
    .wdata(item_r.point_force),
    .raddr(rd_idx_r[cpta_pkg::IDX_W-1:0]),
    .rdata(force_rdata)
  );

  assign busy      = (state_r != cpta_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign is_frame  = (item_r.opcode == cpta_pkg::OP_FRAME);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = cpta_pkg::CNT_W'(1);
    end else if (int'(cap_r) > cpta_pkg::TABLE_DEPTH) begin
      cap_eff = cpta_pkg::CNT_W'(cpta_pkg::TABLE_DEPTH);
    end else begin
      cap_eff = cpta_pkg::CNT_W'(cap_r);
    end
  end

  assign full = (occ_r >= cap_eff);

  // Stage 1: absolute coordinate differences, squares and the weighted force.
  assign dx = {item_r.pos_x[cpta_pkg::POS_W-1], item_r.pos_x}
            - {geo_rdata.pos_x[cpta_pkg::POS_W-1], geo_rdata.pos_x};
  assign dy = {item_r.pos_y[cpta_pkg::POS_W-1], item_r.pos_y}
            - {geo_rdata.pos_y[cpta_pkg::POS_W-1], geo_rdata.pos_y};
  assign dz = {item_r.pos_z[cpta_pkg::POS_W-1], item_r.pos_z}
            - {geo_rdata.pos_z[cpta_pkg::POS_W-1], geo_rdata.pos_z};
  assign ax = dx[cpta_pkg::POS_W] ? cpta_pkg::POS_W'(-dx) : dx[cpta_pkg::POS_W-1:0];
  assign ay = dy[cpta_pkg::POS_W] ? cpta_pkg::POS_W'(-dy) : dy[cpta_pkg::POS_W-1:0];
  assign az = dz[cpta_pkg::POS_W] ? cpta_pkg::POS_W'(-dz) : dz[cpta_pkg::POS_W-1:0];
  assign sqx_nxt  = ax * ax;
  assign sqy_nxt  = ay * ay;
  assign sqz_nxt  = az * az;
  assign prod_nxt = geo_rdata.affect * force_rdata;

  // Stage 2: distance compare.
  assign dist_sq = cpta_pkg::DIST_W'(sqx_r) + cpta_pkg::DIST_W'(sqy_r)
                 + cpta_pkg::DIST_W'(sqz_r);
  assign hit  = (state_r == cpta_pkg::S_SCAN) && v2_r && !is_frame
             && (cpta_pkg::THR_W'(dist_sq) < thr_r);

  assign more  = (rd_idx_r < occ_r);
  assign issue = (state_r == cpta_pkg::S_SCAN) && more && !hit;

  assign acc_shift = acc_r >> cpta_pkg::FRAC_SHIFT;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpta_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == cpta_pkg::OP_ADD
              && in_item.point_force < min_force_r) begin
            state_nxt = cpta_pkg::S_DONE;
          end else begin
            state_nxt = cpta_pkg::S_SCAN;
          end
        end
      end
      cpta_pkg::S_SCAN: begin
        // The entry in stage 2 is settled at this edge, so only stage 1 and
        // pending reads keep the walk going.
        if (hit || (!more && !v1_r)) begin
          state_nxt = cpta_pkg::S_DONE;
        end
      end
      cpta_pkg::S_DONE: begin
        state_nxt = cpta_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cpta_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    item_nxt      = item_r;
    drop_nxt      = drop_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    rd_idx_nxt    = rd_idx_r;
    v1_nxt        = issue;
    v2_nxt        = v1_r && (state_r == cpta_pkg::S_SCAN) && !hit;
    idx1_nxt      = rd_idx_r[cpta_pkg::IDX_W-1:0];
    idx2_nxt      = idx1_r;
    acc_nxt       = acc_r;
    low_force_nxt = low_force_r;
    low_idx_nxt   = low_idx_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    geo_we        = 1'b0;
    force_we      = 1'b0;
    waddr         = hit_idx_r;
    geo_wdata.affect = item_r.affect_weight;
    geo_wdata.pos_x  = item_r.pos_x;
    geo_wdata.pos_y  = item_r.pos_y;
    geo_wdata.pos_z  = item_r.pos_z;
    case (state_r)
      cpta_pkg::S_IDLE: begin
        if (accept) begin
          item_nxt   = in_item;
          drop_nxt   = (in_item.opcode == cpta_pkg::OP_ADD)
                    && (in_item.point_force < min_force_r);
          hit_nxt    = 1'b0;
          rd_idx_nxt = '0;
          acc_nxt    = '0;
        end
      end
      cpta_pkg::S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + cpta_pkg::CNT_W'(1);
        end
        // Weakest entry: lowest force, first index on a tie.
        if (v1_r && (idx1_r == '0 || force_rdata < low_force_r)) begin
          low_force_nxt = force_rdata;
          low_idx_nxt   = idx1_r;
        end
        if (v2_r && is_frame) begin
          acc_nxt = acc_r + cpta_pkg::ACC_W'(prod_r);
        end
        if (hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx2_r;
        end
      end
      cpta_pkg::S_DONE: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.frame_sum   = '0;
        out_item_nxt.add_status  = cpta_pkg::ST_NONE;
        if (is_frame) begin
          occ_nxt = '0;
          if (acc_shift > cpta_pkg::ACC_W'(cpta_pkg::SUM_MAX)) begin
            out_item_nxt.frame_sum = cpta_pkg::SUM_MAX;
          end else begin
            out_item_nxt.frame_sum = cpta_pkg::SUM_W'(acc_shift);
          end
        end else if (!drop_r) begin
          if (hit_r) begin
            force_we                = 1'b1;
            out_item_nxt.add_status = cpta_pkg::ST_MERGED;
          end else if (full) begin
            geo_we                  = 1'b1;
            force_we                = 1'b1;
            waddr                   = low_idx_r;
            out_item_nxt.add_status = cpta_pkg::ST_REPLACED;
          end else begin
            geo_we                  = 1'b1;
            force_we                = 1'b1;
            waddr                   = occ_r[cpta_pkg::IDX_W-1:0];
            occ_nxt                 = occ_r + cpta_pkg::CNT_W'(1);
            out_item_nxt.add_status = cpta_pkg::ST_APPENDED;
          end
        end
        out_item_nxt.entry_count = occ_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpta_pkg::S_IDLE;
      occ_r       <= '0;
      rd_idx_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= cpta_pkg::DIST_THR_RST;
      min_force_r <= cpta_pkg::MIN_FORCE_RST;
      cap_r       <= cpta_pkg::CAP_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_idx_r    <= rd_idx_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cpta_pkg::CFG_DIST_THR:  thr_r       <= cfg_wdata[cpta_pkg::THR_W-1:0];
          cpta_pkg::CFG_MIN_FORCE: min_force_r <= cfg_wdata[cpta_pkg::FORCE_W-1:0];
          cpta_pkg::CFG_CAP_LIMIT: cap_r       <= cfg_wdata[cpta_pkg::CAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    drop_r      <= drop_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    idx1_r      <= idx1_nxt;
    idx2_r      <= idx2_nxt;
    sqx_r       <= sqx_nxt;
    sqy_r       <= sqy_nxt;
    sqz_r       <= sqz_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    low_force_r <= low_force_nxt;
    low_idx_r   <= low_idx_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

### sim/contact_point_table_aggregator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for contact_point_table_aggregator: directed beats,
// then random phases under several register settings. Depends on cpta_pkg.
module contact_point_table_aggregator_test;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam logic signed [cpta_pkg::POS_W-1:0] POS_MAX =
    {1'b0, {(cpta_pkg::POS_W-1){1'b1}}};
  localparam logic signed [cpta_pkg::POS_W-1:0] POS_MIN =
    {1'b1, {(cpta_pkg::POS_W-1){1'b0}}};

  typedef struct {
    cpta_pkg::in_item_t  item;
    bit                  typed;
    cpta_pkg::out_item_t want;
  } stim_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  cpta_pkg::in_item_t             in_item;
  logic                           out_valid;
  cpta_pkg::out_item_t            out_item;
  logic                           cfg_we;
  logic [cpta_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cpta_pkg::CFG_W-1:0]     cfg_wdata;

  // Shadow of the contact table and of the registers.
  logic signed [cpta_pkg::POS_W-1:0] tbl_x [cpta_pkg::TABLE_DEPTH];
  logic signed [cpta_pkg::POS_W-1:0] tbl_y [cpta_pkg::TABLE_DEPTH];
  logic signed [cpta_pkg::POS_W-1:0] tbl_z [cpta_pkg::TABLE_DEPTH];
  logic [cpta_pkg::FORCE_W-1:0]      tbl_force [cpta_pkg::TABLE_DEPTH];
  logic [cpta_pkg::AFFECT_W-1:0]     tbl_affect [cpta_pkg::TABLE_DEPTH];
  int                                tbl_count;
  logic [cpta_pkg::THR_W-1:0]        thr_reg;
  logic [cpta_pkg::FORCE_W-1:0]      min_reg;
  logic [cpta_pkg::CAP_W-1:0]        cap_reg;

  cpta_pkg::out_item_t outcome_q [$];
  stim_row_t           drill_rows [$];
  bit                  row_typed;
  cpta_pkg::out_item_t row_expect;
  cpta_pkg::out_item_t exp_beat;
  cpta_pkg::out_item_t predicted;
  int                  beats_taken;
  int                  failures;
  int                  idle_pct;
  int                  stall;

  contact_point_table_aggregator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one beat to the shadow table and returns the result it must give.
  function automatic cpta_pkg::out_item_t apply_contact_item(cpta_pkg::in_item_t it);
    cpta_pkg::out_item_t r;
    logic [63:0] acc;
    logic [63:0] dsq;
    logic signed [63:0] dx, dy, dz;
    logic signed [cpta_pkg::POS_W-1:0] px, py, pz;
    int i, cap, low, hit, slot;
    r = '0;
    r.add_status = cpta_pkg::ST_NONE;
    if (it.opcode == cpta_pkg::OP_FRAME) begin
      acc = '0;
      for (i = 0; i < tbl_count; i++)
        acc += 64'(tbl_affect[i]) * 64'(tbl_force[i]);
      acc = acc >> cpta_pkg::FRAC_SHIFT;
      r.frame_sum = (acc > 64'(cpta_pkg::SUM_MAX)) ? cpta_pkg::SUM_MAX
                                                   : acc[cpta_pkg::SUM_W-1:0];
      tbl_count = 0;
    end else begin
      px = it.pos_x;
      py = it.pos_y;
      pz = it.pos_z;
      cap = int'(cap_reg);
      if (cap < 1) cap = 1;
      if (cap > cpta_pkg::TABLE_DEPTH) cap = cpta_pkg::TABLE_DEPTH;
      if (it.point_force >= min_reg) begin
        low = 0;
        hit = -1;
        for (i = 0; i < tbl_count && hit < 0; i++) begin
          dx = longint'(tbl_x[i]) - longint'(px);
          dy = longint'(tbl_y[i]) - longint'(py);
          dz = longint'(tbl_z[i]) - longint'(pz);
          dsq = dx * dx + dy * dy + dz * dz;
          if (dsq < 64'(thr_reg)) begin
            // Only the force of the first close entry is refreshed.
            tbl_force[i] = it.point_force;
            hit = i;
          end else if (tbl_force[i] < tbl_force[low]) begin
            low = i;
          end
        end
        if (hit >= 0) begin
          r.add_status = cpta_pkg::ST_MERGED;
        end else begin
          if (tbl_count >= cap) begin
            slot = low;
            r.add_status = cpta_pkg::ST_REPLACED;
          end else begin
            slot = tbl_count;
            tbl_count++;
            r.add_status = cpta_pkg::ST_APPENDED;
          end
          tbl_x[slot]      = px;
          tbl_y[slot]      = py;
          tbl_z[slot]      = pz;
          tbl_force[slot]  = it.point_force;
          tbl_affect[slot] = it.affect_weight;
        end
      end
    end
    r.entry_count = cpta_pkg::CNT_W'(tbl_count);
    return r;
  endfunction

  function automatic cpta_pkg::in_item_t contact_add(
      logic signed [cpta_pkg::POS_W-1:0] x,
      logic signed [cpta_pkg::POS_W-1:0] y,
      logic signed [cpta_pkg::POS_W-1:0] z,
      logic [cpta_pkg::FORCE_W-1:0]      f,
      logic [cpta_pkg::AFFECT_W-1:0]     a);
    cpta_pkg::in_item_t it;
    it.opcode        = cpta_pkg::OP_ADD;
    it.pos_x         = x;
    it.pos_y         = y;
    it.pos_z         = z;
    it.point_force   = f;
    it.affect_weight = a;
    return it;
  endfunction

  function automatic cpta_pkg::out_item_t mk_want(cpta_pkg::status_t st,
                                                  logic [cpta_pkg::SUM_W-1:0] s,
                                                  int c);
    cpta_pkg::out_item_t r;
    r.add_status  = st;
    r.frame_sum   = s;
    r.entry_count = cpta_pkg::CNT_W'(c);
    return r;
  endfunction

  // Appends one row to the directed stimulus table.
  function automatic void add_row(cpta_pkg::in_item_t it, bit typed,
                                  cpta_pkg::out_item_t w);
    stim_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = w;
    drill_rows = {drill_rows, r};
  endfunction

  // Mostly points near stored entries or on a coarse grid, so merges and
  // replacements happen; the rest is full-range noise.
  function automatic cpta_pkg::in_item_t random_item();
    cpta_pkg::in_item_t it;
    int pick, j;
    it.opcode        = cpta_pkg::op_t'($urandom_range(1));
    it.pos_x         = cpta_pkg::POS_W'($urandom);
    it.pos_y         = cpta_pkg::POS_W'($urandom);
    it.pos_z         = cpta_pkg::POS_W'($urandom);
    it.point_force   = $urandom;
    it.affect_weight = cpta_pkg::AFFECT_W'($urandom);
    if ($urandom_range(11) == 0) begin
      it.opcode = cpta_pkg::OP_FRAME;
      return it;
    end
    it.opcode = cpta_pkg::OP_ADD;
    pick = $urandom_range(9);
    if (pick < 5 && tbl_count > 0) begin
      j = $urandom_range(tbl_count - 1);
      it.pos_x = cpta_pkg::POS_W'(int'(tbl_x[j]) + int'($urandom_range(1400)) - 700);
      it.pos_y = cpta_pkg::POS_W'(int'(tbl_y[j]) + int'($urandom_range(1400)) - 700);
      it.pos_z = cpta_pkg::POS_W'(int'(tbl_z[j]) + int'($urandom_range(1400)) - 700);
    end else if (pick < 8) begin
      it.pos_x = cpta_pkg::POS_W'((int'($urandom_range(7)) - 4) * 65536);
      it.pos_y = cpta_pkg::POS_W'((int'($urandom_range(3)) - 2) * 65536);
      it.pos_z = cpta_pkg::POS_W'((int'($urandom_range(3)) - 2) * 65536);
    end
    case ($urandom_range(7))
      0: it.point_force = min_reg;
      1: it.point_force = min_reg - 1;
      2: it.point_force = '0;
      3: it.point_force = '1;
      4: it.point_force = 1000 * (1 + $urandom_range(3));
      default: ;
    endcase
    case ($urandom_range(7))
      0: it.affect_weight = '0;
      1: it.affect_weight = '1;
      default: ;
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    failures++;
    if (failures <= REPORT_MAX)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(cpta_pkg::in_item_t it, bit typed, cpta_pkg::out_item_t w);
    int n0;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_item    = it;
    row_typed  = typed;
    row_expect = w;
    start      = 1'b1;
    n0 = beats_taken;
    do @(negedge clk); while (beats_taken == n0);
  endtask

  task automatic configure(logic [cpta_pkg::THR_W-1:0] thr,
                           logic [cpta_pkg::FORCE_W-1:0] fmin,
                           logic [cpta_pkg::CAP_W-1:0] cap);
    start = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = cpta_pkg::CFG_DIST_THR;
    cfg_wdata = cpta_pkg::CFG_W'(thr);
    thr_reg   = thr;
    @(negedge clk);
    cfg_index = cpta_pkg::CFG_MIN_FORCE;
    cfg_wdata = cpta_pkg::CFG_W'(fmin);
    min_reg   = fmin;
    @(negedge clk);
    cfg_index = cpta_pkg::CFG_CAP_LIMIT;
    cfg_wdata = cpta_pkg::CFG_W'(cap);
    cap_reg   = cap;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(0), 64'(out_item));
        end else begin
          exp_beat = outcome_q.pop_front();
          if (out_item.add_status !== exp_beat.add_status)
            report_mismatch("add_status", 64'(exp_beat.add_status),
                            64'(out_item.add_status));
          if (out_item.frame_sum !== exp_beat.frame_sum)
            report_mismatch("frame_sum", 64'(exp_beat.frame_sum),
                            64'(out_item.frame_sum));
          if (out_item.entry_count !== exp_beat.entry_count)
            report_mismatch("entry_count", 64'(exp_beat.entry_count),
                            64'(out_item.entry_count));
        end
      end
      if (start && !busy) begin
        predicted = apply_contact_item(in_item);
        outcome_q = {outcome_q, (row_typed ? row_expect : predicted)};
        beats_taken++;
      end
    end
  end

  initial begin
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (start && !busy) || out_valid === 1'b1)
        stall = 0;
      else
        stall++;
    end
    $display("contact_point_table_aggregator_test NOT OK");
    $finish;
  end

  initial begin
    int k, ph, n, sent, len;
    logic [cpta_pkg::THR_W-1:0]   p_thr;
    logic [cpta_pkg::FORCE_W-1:0] p_min;
    logic [cpta_pkg::CAP_W-1:0]   p_cap;
    cpta_pkg::in_item_t           it;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_index   = cpta_pkg::CFG_DIST_THR;
    cfg_wdata   = '0;
    row_typed   = 1'b0;
    row_expect  = '0;
    beats_taken = 0;
    failures    = 0;
    idle_pct    = 38;
    tbl_count   = 0;
    thr_reg     = cpta_pkg::DIST_THR_RST;
    min_reg     = cpta_pkg::MIN_FORCE_RST;
    cap_reg     = cpta_pkg::CAP_LIMIT_RST;
    for (k = 0; k < cpta_pkg::TABLE_DEPTH; k++) begin
      tbl_x[k] = '0; tbl_y[k] = '0; tbl_z[k] = '0;
      tbl_force[k] = '0; tbl_affect[k] = '0;
    end

    // Frame beat with every ignored field set, on an empty table.
    it = '1;
    it.opcode = cpta_pkg::OP_FRAME;
    add_row(it, 1, mk_want(cpta_pkg::ST_NONE, '0, 0));
    // Forces below the default minimum are dropped.
    add_row(contact_add(0, 0, 0, 0, '1), 1, mk_want(cpta_pkg::ST_NONE, '0, 0));
    add_row(contact_add(0, 0, 0, 654, 1), 1, mk_want(cpta_pkg::ST_NONE, '0, 0));
    add_row(contact_add(POS_MAX, POS_MAX, POS_MAX, 655, '1), 1,
            mk_want(cpta_pkg::ST_APPENDED, '0, 1));
    add_row(contact_add(POS_MIN, POS_MIN, POS_MIN, '1, '1), 1,
            mk_want(cpta_pkg::ST_APPENDED, '0, 2));
    add_row(contact_add(cpta_pkg::POS_W'(POS_MIN + 1), POS_MIN, POS_MIN, 1000, 0), 1,
            mk_want(cpta_pkg::ST_MERGED, '0, 2));
    add_row(it, 0, '0);
    add_row(contact_add(0, 0, 0, 32'h10000, 16'h8000), 1,
            mk_want(cpta_pkg::ST_APPENDED, '0, 1));
    // Squared distance exactly at the default threshold does not merge;
    // one step closer it merges into the first entry, not the second.
    add_row(contact_add(653, 48, 28, 3000, 16'h4000), 0, '0);
    add_row(contact_add(653, 48, 27, 5000, 16'h7FFF), 0, '0);
    // Fill to the default capacity with two entries tied for weakest.
    for (k = 1; k <= 8; k++)
      add_row(contact_add(cpta_pkg::POS_W'(k << 16), 0, 0,
                          cpta_pkg::FORCE_W'((k == 3 || k == 6) ? 700 : 1000 * k + 2000),
                          cpta_pkg::AFFECT_W'(k * 16'h1000)), 0, '0);
    add_row(contact_add(0, 24'h100000, 0, 2048, 16'h1234), 0, '0);
    add_row(contact_add(0, 24'h200000, 0, 900, 16'hFFFF), 0, '0);
    add_row(it, 0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (drill_rows[r])
      send_beat(drill_rows[r].item, drill_rows[r].typed, drill_rows[r].want);

    sent = 0;
    for (ph = 0; ph < 9; ph++) begin
      len = 90;
      case (ph)
        1: begin p_thr = '0;          p_min = '0;    p_cap = 1;  end
        2: begin p_thr = '1;          p_min = '1;    p_cap = 16; len = 40; end
        3: begin p_thr = 4000000;     p_min = 1000;  p_cap = 0;  end
        4: begin p_thr = 429497;      p_min = 655;   p_cap = 31; len = 100; end
        5: begin p_thr = 100000;      p_min = 2000;  p_cap = 17; end
        6: begin p_thr = 2000000;     p_min = 0;     p_cap = 4;  len = 100; end
        7: begin p_thr = 52'd1 << 33; p_min = 500;   p_cap = 2;  end
        default: begin
          p_thr = cpta_pkg::DIST_THR_RST;
          p_min = cpta_pkg::MIN_FORCE_RST;
          p_cap = cpta_pkg::CAP_LIMIT_RST;
        end
      endcase
      if (ph > 0)
        configure(p_thr, p_min, p_cap);
      for (n = 0; n < len; n++) begin
        idle_pct = (sent < 260) ? 38 : (sent < 520) ? 75 : 0;
        send_beat(random_item(), 0, '0);
        sent++;
      end
    end

    start = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    failures += outcome_q.size();
    if (failures == 0)
      $display("contact_point_table_aggregator_test OK");
    else
      $display("contact_point_table_aggregator_test NOT OK");
    $finish;
  end

endmodule

### filelist.f
src/cpta_pkg.sv
src/cpta_ram.sv
src/contact_point_table_aggregator.sv
sim/contact_point_table_aggregator_test.sv
